// File: hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and the CORDIC arc table of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    // CORDIC datapath: vectors normalised to [2^39, 2^40), gain and prerotation
    // headroom on top
    localparam int CORDIC_W  = 44;
    localparam int NORM_BITS = 40;
    localparam int NORM_CNT  = 6;
    // angle accumulator, 2^32 per turn
    localparam int ACC_W     = 34;
    localparam int LANES     = 3;
    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] x;
    } t_vec;

    // atan(2^-i), 2^32 per turn
    function automatic logic [31:0] arc_angle(input int unsigned idx);
        logic [31:0] a;
        case (idx)
            0:  a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
            3:  a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
            9:  a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
            12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2FA;
            15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
            18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
            21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
            24: a = 32'h00000029; 25: a = 32'h00000014; 26: a = 32'h0000000A;
            27: a = 32'h00000005; 28: a = 32'h00000003; 29: a = 32'h00000001;
            30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/qte_if.sv
// ----------------------------------------------------------------------------
// qte_if
// Valid/ready channels for quaternion input and Euler angle output.
// ----------------------------------------------------------------------------
interface qte_in_if #(parameter int COMP_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] comp_w;
    logic signed [COMP_WIDTH-1:0] comp_x;
    logic signed [COMP_WIDTH-1:0] comp_y;
    logic signed [COMP_WIDTH-1:0] comp_z;
    modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
    modport sink   (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

interface qte_out_if #(parameter int ANGLE_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

// File: hdl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Attitude quaternion (Q2.x) to ZYX yaw, pitch and roll binary angles.
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion is taken every cycle unless the output
// stalls, and each result passes through a chain of registered cells: three
// front-end stages (products, sums, square of the pitch sine), one
// square-root cell per root bit, six normalising shifter cells, a quarter-turn
// prerotation, one CORDIC cell per micro-rotation and the output register.
// Pitch uses atan2(t, sqrt(1-t^2)) on the clamped sine. A stall on the output
// freezes every stage, empty slots included, until the waiting transaction is
// taken.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
    parameter int COMP_WIDTH    = 16,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qte_in_if.sink           i_quat,
    qte_out_if.source        o_euler
);
    localparam int F   = COMP_WIDTH - 2;
    localparam int PW  = 2 * COMP_WIDTH;
    // 2*(sum of two products) reaches +2^(COMP_WIDTH+2)
    localparam int TW  = COMP_WIDTH + 4;
    localparam int RW  = 2 * F + 1;
    localparam int QW  = F + 1;
    localparam int SW  = 5 * TW;
    localparam int SQW = 2 * F + 4;
    localparam int CW  = qte_pkg::CORDIC_W;
    localparam int AW  = qte_pkg::ACC_W;
    localparam int NS  = qte_pkg::NORM_CNT;
    localparam int NZ  = NS + 1 + CORDIC_STAGES;
    localparam int L   = 11 + QW + CORDIC_STAGES;
    localparam int SH  = 32 - ANGLE_WIDTH;
    localparam logic signed [TW-1:0] ONE = TW'(1) <<< F;
    localparam logic signed [SQW-1:0] ONE_SQ = SQW'(1) <<< (2 * F);
    localparam logic signed [AW-1:0] HALF = (SH == 0) ? '0 : (AW'(1) <<< (SH - 1));
    localparam logic signed [AW-1:0] QUART = AW'(1) <<< (ANGLE_WIDTH - 2);
    localparam logic signed [AW-1:0] PRE = AW'(1) <<< 30;
    localparam logic signed [ANGLE_WIDTH-1:0] QUART_O = ANGLE_WIDTH'(1) <<< (ANGLE_WIDTH - 2);

    logic         en;
    logic [L-1:0] r_vld;

    assign en           = !r_vld[L-1] || o_euler.ready;
    assign i_quat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_quat.valid};
        end
    end

    // stage 1: products
    logic signed [PW-1:0] r_wz, r_xy, r_yy, r_zz, r_wy, r_zx, r_wx, r_yz, r_xx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wz <= i_quat.comp_w * i_quat.comp_z;
            r_xy <= i_quat.comp_x * i_quat.comp_y;
            r_yy <= i_quat.comp_y * i_quat.comp_y;
            r_zz <= i_quat.comp_z * i_quat.comp_z;
            r_wy <= i_quat.comp_w * i_quat.comp_y;
            r_zx <= i_quat.comp_z * i_quat.comp_x;
            r_wx <= i_quat.comp_w * i_quat.comp_x;
            r_yz <= i_quat.comp_y * i_quat.comp_z;
            r_xx <= i_quat.comp_x * i_quat.comp_x;
        end
    end

    // stage 2: floor shift to F fraction bits, form the atan2 arguments and clamp the pitch sine
    logic signed [TW-1:0] n_t0, n_t1, n_t2, n_t3, n_t4, t2_raw;
    logic signed [TW-1:0] r_t0, r_t1, r_t2, r_t3, r_t4;
    always_comb begin
        n_t3   = (TW'(r_wz >>> F) + TW'(r_xy >>> F)) <<< 1;
        n_t4   = ONE - ((TW'(r_yy >>> F) + TW'(r_zz >>> F)) <<< 1);
        t2_raw = (TW'(r_wy >>> F) - TW'(r_zx >>> F)) <<< 1;
        n_t0   = (TW'(r_wx >>> F) + TW'(r_yz >>> F)) <<< 1;
        n_t1   = ONE - ((TW'(r_xx >>> F) + TW'(r_yy >>> F)) <<< 1);
        if (t2_raw > ONE) begin
            n_t2 = ONE;
        end else if (t2_raw < -ONE) begin
            n_t2 = -ONE;
        end else begin
            n_t2 = t2_raw;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t0 <= n_t0; r_t1 <= n_t1; r_t2 <= n_t2; r_t3 <= n_t3; r_t4 <= n_t4;
        end
    end

    // stage 3: radicand 1 - t^2
    logic signed [F+1:0]  t2_n;
    logic signed [SQW-1:0] t2_sq, rad_full;
    logic [RW-1:0]         r_rad;
    logic [SW-1:0]         r_side3;
    always_comb begin
        t2_n     = r_t2[F+1:0];
        t2_sq    = t2_n * t2_n;
        rad_full = ONE_SQ - t2_sq;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad   <= rad_full[RW-1:0];
            r_side3 <= {r_t0, r_t1, r_t2, r_t3, r_t4};
        end
    end

    // square-root chain, most significant root bit first
    logic [RW-1:0] sq_rem  [0:QW];
    logic [QW-1:0] sq_root [0:QW];
    logic [SW-1:0] sq_side [0:QW];
    assign sq_rem[0]  = r_rad;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_side3;

    for (genvar k = 0; k < QW; k++) begin : g_sqrt
        qte_sqrt_cell #(.RW(RW), .QW(QW), .SW(SW), .BIT(F - k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .i_side (sq_side[k]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1]),
            .o_side (sq_side[k+1])
        );
    end

    // lane vectors into the normaliser
    logic signed [TW-1:0] s_t0, s_t1, s_t2, s_t3, s_t4;
    qte_pkg::t_vec        nv [qte_pkg::LANES][0:NS];
    logic [qte_pkg::LANES-1:0] zero_in;
    assign {s_t0, s_t1, s_t2, s_t3, s_t4} = sq_side[QW];

    always_comb begin
        nv[qte_pkg::LANE_YAW][0].y   = CW'(s_t3);
        nv[qte_pkg::LANE_YAW][0].x   = CW'(s_t4);
        nv[qte_pkg::LANE_PITCH][0].y = CW'(s_t2);
        nv[qte_pkg::LANE_PITCH][0].x = {{(CW-QW){1'b0}}, sq_root[QW]};
        nv[qte_pkg::LANE_ROLL][0].y  = CW'(s_t0);
        nv[qte_pkg::LANE_ROLL][0].x  = CW'(s_t1);
        for (int l = 0; l < qte_pkg::LANES; l++) begin
            zero_in[l] = (nv[l][0].x == '0) && (nv[l][0].y == '0);
        end
    end

    // atan2(0, 0) is forced to zero at the output
    logic [qte_pkg::LANES-1:0] r_zero [0:NZ-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= zero_in;
            for (int d = 1; d < NZ; d++) begin
                r_zero[d] <= r_zero[d-1];
            end
        end
    end

    qte_pkg::t_vec          r_pre_vec [qte_pkg::LANES];
    logic signed [AW-1:0]   r_pre_ang [qte_pkg::LANES];
    qte_pkg::t_vec          cv [qte_pkg::LANES][0:CORDIC_STAGES];
    logic signed [AW-1:0]   ca [qte_pkg::LANES][0:CORDIC_STAGES];

    for (genvar l = 0; l < qte_pkg::LANES; l++) begin : g_lane
        for (genvar s = 0; s < NS; s++) begin : g_norm
            qte_norm_cell #(.SHIFT(1 << (NS - 1 - s))) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_vec (nv[l][s]),
                .o_vec (nv[l][s+1])
            );
        end

        // quarter-turn prerotation into the right half plane
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (nv[l][NS].x < 0) begin
                    if (nv[l][NS].y >= 0) begin
                        r_pre_vec[l].x <= nv[l][NS].y;
                        r_pre_vec[l].y <= -nv[l][NS].x;
                        r_pre_ang[l]   <= PRE;
                    end else begin
                        r_pre_vec[l].x <= -nv[l][NS].y;
                        r_pre_vec[l].y <= nv[l][NS].x;
                        r_pre_ang[l]   <= -PRE;
                    end
                end else begin
                    r_pre_vec[l] <= nv[l][NS];
                    r_pre_ang[l] <= '0;
                end
            end
        end

        assign cv[l][0] = r_pre_vec[l];
        assign ca[l][0] = r_pre_ang[l];

        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
            qte_cordic_cell #(.IDX(s)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_vec (cv[l][s]),
                .i_ang (ca[l][s]),
                .o_vec (cv[l][s+1]),
                .o_ang (ca[l][s+1])
            );
        end
    end

    // output: round to ANGLE_WIDTH, saturate pitch, wrap
    logic signed [AW-1:0]          rnd [qte_pkg::LANES];
    logic signed [AW-1:0]          pitch_sat;
    logic signed [ANGLE_WIDTH-1:0] r_yaw, r_pitch, r_roll;
    logic [qte_pkg::LANES-1:0]     r_zero_o;
    always_comb begin
        for (int l = 0; l < qte_pkg::LANES; l++) begin
            rnd[l] = (ca[l][CORDIC_STAGES] + HALF) >>> SH;
        end
        if (rnd[qte_pkg::LANE_PITCH] > QUART) begin
            pitch_sat = QUART;
        end else if (rnd[qte_pkg::LANE_PITCH] < -QUART) begin
            pitch_sat = -QUART;
        end else begin
            pitch_sat = rnd[qte_pkg::LANE_PITCH];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero_o <= r_zero[NZ-1];
            r_yaw    <= r_zero[NZ-1][qte_pkg::LANE_YAW] ? '0 :
                        rnd[qte_pkg::LANE_YAW][ANGLE_WIDTH-1:0];
            r_pitch  <= r_zero[NZ-1][qte_pkg::LANE_PITCH] ? '0 : pitch_sat[ANGLE_WIDTH-1:0];
            r_roll   <= r_zero[NZ-1][qte_pkg::LANE_ROLL] ? '0 :
                        rnd[qte_pkg::LANE_ROLL][ANGLE_WIDTH-1:0];
        end
    end

    assign o_euler.valid       = r_vld[L-1];
    assign o_euler.yaw_angle   = r_yaw;
    assign o_euler.pitch_angle = r_pitch;
    assign o_euler.roll_angle  = r_roll;

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> (o_euler.pitch_angle <= QUART_O && o_euler.pitch_angle >= -QUART_O))
        else $error("pitch outside quarter turn");

    a_zero_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_euler.valid && r_zero_o[qte_pkg::LANE_YAW]) |-> (o_euler.yaw_angle == '0))
        else $error("zero vector yaw not zero");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2+QW] |-> ({1'b0, sq_root[QW]} <= (QW+1)'(1) << F))
        else $error("pitch cosine above one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_vld[0]) |=> r_vld[0])
        else $error("pipeline slot lost during stall");
endmodule

// File: hdl/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One digit of a pipelined restoring square root, with side payload.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
    parameter int RW  = 29,
    parameter int QW  = 15,
    parameter int SW  = 8,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_root,
    input  logic [SW-1:0] i_side,
    output logic [RW-1:0] o_rem,
    output logic [QW-1:0] o_root,
    output logic [SW-1:0] o_side
);
    logic [RW+1:0] trial;
    logic [RW+1:0] rem_x;
    logic [RW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_root, n_root;
    logic [SW-1:0] r_side;

    // (Q + 2^b)^2 - Q^2 = Q*2^(b+1) + 2^(2b)
    always_comb begin
        trial = ({{(RW+2-QW){1'b0}}, i_root} << (BIT+1)) + ((RW+2)'(1) << (2*BIT));
        rem_x = {2'b00, i_rem};
        if (rem_x >= trial) begin
            n_rem  = RW'(rem_x - trial);
            n_root = i_root | (QW'(1) << BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

// File: hdl/qte_norm_cell.sv
// ----------------------------------------------------------------------------
// qte_norm_cell
// One step of the normalising shifter: doubles the vector SHIFT times if
// that keeps it below 2^40.
// ----------------------------------------------------------------------------
module qte_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  qte_pkg::t_vec i_vec,
    output qte_pkg::t_vec o_vec
);
    logic signed [qte_pkg::CORDIC_W-1:0] vx, vy, ax, ay;
    logic                                fits;
    qte_pkg::t_vec                       r_vec, n_vec;

    always_comb begin
        vx   = i_vec.x;
        vy   = i_vec.y;
        ax   = (vx < 0) ? -vx : vx;
        ay   = (vy < 0) ? -vy : vy;
        fits = ((ax | ay) >> (qte_pkg::NORM_BITS - SHIFT)) == '0;
        n_vec.x = fits ? (vx <<< SHIFT) : vx;
        n_vec.y = fits ? (vy <<< SHIFT) : vy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;
endmodule

// File: hdl/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring micro-rotation by atan(2^-IDX) with angle accumulation.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  qte_pkg::t_vec                    i_vec,
    input  logic signed [qte_pkg::ACC_W-1:0] i_ang,
    output qte_pkg::t_vec                    o_vec,
    output logic signed [qte_pkg::ACC_W-1:0] o_ang
);
    localparam logic signed [qte_pkg::ACC_W-1:0] ARC =
        {2'b00, qte_pkg::arc_angle(IDX)};

    logic signed [qte_pkg::CORDIC_W-1:0] vx, vy, dx, dy;
    qte_pkg::t_vec                       r_vec, n_vec;
    logic signed [qte_pkg::ACC_W-1:0]    r_ang, n_ang;

    always_comb begin
        vx = i_vec.x;
        vy = i_vec.y;
        dx = vy >>> IDX;
        dy = vx >>> IDX;
        if (vy >= 0) begin
            n_vec.x = vx + dx;
            n_vec.y = vy - dy;
            n_ang   = i_ang + ARC;
        end else begin
            n_vec.x = vx - dx;
            n_vec.y = vy + dy;
            n_ang   = i_ang - ARC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
            r_ang <= n_ang;
        end
    end

    assign o_vec = r_vec;
    assign o_ang = r_ang;
endmodule
